// ----- rtl/md5_pkg.sv -----
// md5_pkg: shared types, constants and helper functions of the md5 digest unit
`timescale 1ns / 1ps

package md5_pkg;

    // chaining word initial values
    localparam logic [31:0] IvA = 32'h67452301;
    localparam logic [31:0] IvB = 32'hefcdab89;
    localparam logic [31:0] IvC = 32'h98badcfe;
    localparam logic [31:0] IvD = 32'h10325476;

    // first padding byte
    localparam logic [7:0] PadByte = 8'h80;

    // default depth of the word queue between front and back
    localparam int WqDepth = 4;

    // per-step additive constants (integer part of abs(sin(i+1)) * 2^32)
    localparam logic [31:0] RoundConst [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    // one request of the word queue: a packed block word
    typedef struct packed {
        logic [31:0] word;
        logic        msg_end;   // last word of the final block of a message
    } wq_entry_t;

    // front status, for checking
    typedef struct packed {
        logic padding;
    } front_status_t;

    // back status, for checking
    typedef struct packed {
        logic rounding;
        logic cmp_bank_full;
    } back_status_t;

    // rotate amount for a given phase and step within the group of four
    function automatic logic [4:0] md5_shift(input logic [1:0] phase, input logic [1:0] step);
        logic [4:0] s;
        case ({phase, step})
            4'h0:    s = 5'd7;
            4'h1:    s = 5'd12;
            4'h2:    s = 5'd17;
            4'h3:    s = 5'd22;
            4'h4:    s = 5'd5;
            4'h5:    s = 5'd9;
            4'h6:    s = 5'd14;
            4'h7:    s = 5'd20;
            4'h8:    s = 5'd4;
            4'h9:    s = 5'd11;
            4'ha:    s = 5'd16;
            4'hb:    s = 5'd23;
            4'hc:    s = 5'd6;
            4'hd:    s = 5'd10;
            4'he:    s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    // message word index used by a step
    function automatic logic [3:0] md5_msg_index(input logic [5:0] step);
        logic [3:0] lo;
        logic [3:0] g;
        lo = step[3:0];
        case (step[5:4])
            2'd0:    g = lo;
            2'd1:    g = 4'((lo << 2) + lo + 4'd1);
            2'd2:    g = 4'((lo << 1) + lo + 4'd5);
            default: g = 4'((lo << 3) - lo);
        endcase
        return g;
    endfunction

    // 32-bit rotate left
    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] dbl;
        dbl = {x, x} << s;
        return dbl[63:32];
    endfunction

endpackage

// ----- rtl/md5_message_digest_unit.sv -----
// md5_message_digest_unit: top level of the byte-serial md5 digest unit
// The unit takes a message one byte per request (last_byte high on the final byte,
// every message at least one byte long) and returns one 128-bit md5 digest per
// message on digest_low / digest_high, digest byte 0 in digest_low[7:0]. A front
// end packs bytes into little-endian words and, after the final byte, generates
// the padding and bit-length words (full stays high meanwhile); a short word
// queue feeds a back end that fills one of two sixteen-word block banks while it
// compresses the other. Compression takes one step per cycle: 64 steps, preceded
// by a bank check and the PRIME0 and PRIME1 set-up states and followed by a
// chaining update; the single round unit sets the sustained block rate. Bytes
// within a block go in one per cycle until the queue and both banks are taken.
// With no earlier block still in the back end, the digest follows the final byte
// once its one or two padded blocks are compressed, later when earlier blocks are
// still pending, and waits in an output register until popped; the next message
// can be pushed meanwhile. There is no clearing pass after reset.
`timescale 1ns / 1ps

module md5_message_digest_unit import md5_pkg::*; #(
    parameter int QueueDepth = WqDepth
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    input  logic        push,
    output logic        full,
    output logic [63:0] digest_low,
    output logic [63:0] digest_high,
    output logic        empty,
    input  logic        pop
);

    wq_entry_t     q_wdata;
    wq_entry_t     q_rdata;
    logic          q_push;
    logic          q_full;
    logic          q_pop;
    logic          q_empty;
    front_status_t fstat;
    back_status_t  bstat;

    // packing and padding
    md5_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (data_byte),
        .last_byte (last_byte),
        .push      (push),
        .full      (full),
        .q_wdata   (q_wdata),
        .q_push    (q_push),
        .q_full    (q_full),
        .fstat     (fstat)
    );

    // word queue
    md5_wq #(
        .Depth (QueueDepth)
    ) u_wq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .wdata (q_wdata),
        .full  (q_full),
        .pop   (q_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    // compression and digest output
    md5_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_rdata     (q_rdata),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .digest_low  (digest_low),
        .digest_high (digest_high),
        .empty       (empty),
        .pop         (pop),
        .bstat       (bstat)
    );

    // the front never pushes a word into a full queue
    a_no_queue_overflow: assert property (
        @(posedge clk) disable iff (!rst_n) q_push |-> !q_full
    ) else $error("word pushed into full queue");

    // compression steps only run on a bank that holds a complete block
    a_round_on_full_bank: assert property (
        @(posedge clk) disable iff (!rst_n) bstat.rounding |-> bstat.cmp_bank_full
    ) else $error("compression running on a bank that is not full");

    // no new byte is taken while padding is generated
    a_full_while_padding: assert property (
        @(posedge clk) disable iff (!rst_n) fstat.padding |-> full
    ) else $error("byte request accepted during padding");

endmodule

// ----- rtl/md5_wq.sv -----
// md5_wq: small word queue between the packing front and the compression back
`timescale 1ns / 1ps

module md5_wq import md5_pkg::*; #(
    parameter int Depth = WqDepth
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  wq_entry_t wdata,
    output logic      full,
    input  logic      pop,
    output wq_entry_t rdata,
    output logic      empty
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    wq_entry_t       mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0] cnt_reg, cnt_next;
    logic            do_push;
    logic            do_pop;

    assign full    = (cnt_reg == CntW'(Depth));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ----- rtl/md5_front.sv -----
// md5_front: byte packing, message length count and padding generation
`timescale 1ns / 1ps

module md5_front import md5_pkg::*; (
    input  logic          clk,
    input  logic          rst_n,
    input  logic [7:0]    data_byte,
    input  logic          last_byte,
    input  logic          push,
    output logic          full,
    output wq_entry_t     q_wdata,
    output logic          q_push,
    input  logic          q_full,
    output front_status_t fstat
);

    typedef enum logic [1:0] {
        FS_ACCEPT = 2'b01,
        FS_PAD    = 2'b10
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [31:0]  word_reg, word_next;
    logic [60:0]  count_reg, count_next;
    logic [3:0]   widx_reg, widx_next;
    logic         first_reg, first_next;
    logic         second_reg, second_next;
    logic         two_reg, two_next;

    logic         accept;
    logic [60:0]  count_inc;
    logic [1:0]   lane;
    logic [31:0]  head_word;
    logic [63:0]  bit_len;
    logic         len_blk;
    logic [31:0]  pad_word;

    assign full        = (state_reg != FS_ACCEPT) || q_full;
    assign accept      = push && !full;
    assign count_inc   = count_reg + 61'd1;
    assign lane        = count_reg[1:0];
    assign bit_len     = {count_reg, 3'b000};
    assign len_blk     = two_reg ? second_reg : 1'b1;
    assign fstat.padding = (state_reg == FS_PAD);

    // first padding word: message bytes below the lane, then the pad byte, then zeros
    always_comb
    begin
        for (int k = 0; k < 4; k++)
        begin
            if (2'(k) < lane)
            begin
                head_word[8*k +: 8] = word_reg[8*k +: 8];
            end
            else if (2'(k) == lane)
            begin
                head_word[8*k +: 8] = PadByte;
            end
            else
            begin
                head_word[8*k +: 8] = 8'h00;
            end
        end
    end

    // padding word select
    always_comb
    begin
        if (first_reg)
        begin
            pad_word = head_word;
        end
        else if (len_blk && (widx_reg == 4'd14))
        begin
            pad_word = bit_len[31:0];
        end
        else if (len_blk && (widx_reg == 4'd15))
        begin
            pad_word = bit_len[63:32];
        end
        else
        begin
            pad_word = '0;
        end
    end

    // control
    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        count_next      = count_reg;
        widx_next       = widx_reg;
        first_next      = first_reg;
        second_next     = second_reg;
        two_next        = two_reg;
        q_push          = 1'b0;
        q_wdata.word    = {data_byte, word_reg[23:0]};
        q_wdata.msg_end = 1'b0;
        case (state_reg)
            FS_ACCEPT:
            begin
                if (accept)
                begin
                    word_next[8*lane +: 8] = data_byte;
                    count_next = count_inc;
                    if (lane == 2'd3)
                    begin
                        q_push = 1'b1;
                    end
                    if (last_byte)
                    begin
                        state_next  = FS_PAD;
                        widx_next   = count_inc[5:2];
                        first_next  = 1'b1;
                        second_next = 1'b0;
                        two_next    = (count_inc[5:3] == 3'b111);
                    end
                end
            end
            FS_PAD:
            begin
                q_push          = !q_full;
                q_wdata.word    = pad_word;
                q_wdata.msg_end = len_blk && (widx_reg == 4'd15);
                if (!q_full)
                begin
                    first_next = 1'b0;
                    widx_next  = widx_reg + 4'd1;
                    if (widx_reg == 4'd15)
                    begin
                        if (two_reg && !second_reg)
                        begin
                            second_next = 1'b1;
                        end
                        else
                        begin
                            state_next = FS_ACCEPT;
                            count_next = '0;
                        end
                    end
                end
            end
            default:
            begin
                state_next = FS_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= FS_ACCEPT;
            count_reg  <= '0;
            widx_reg   <= '0;
            first_reg  <= 1'b0;
            second_reg <= 1'b0;
            two_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            widx_reg   <= widx_next;
            first_reg  <= first_next;
            second_reg <= second_next;
            two_reg    <= two_next;
        end
    end

    // partial word, no reset
    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

endmodule

// ----- rtl/md5_back.sv -----
// md5_back: double-buffered block store, 64-step compression and digest register
`timescale 1ns / 1ps

module md5_back import md5_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    input  wq_entry_t    q_rdata,
    input  logic         q_empty,
    output logic         q_pop,
    output logic [63:0]  digest_low,
    output logic [63:0]  digest_high,
    output logic         empty,
    input  logic         pop,
    output back_status_t bstat
);

    typedef enum logic [5:0] {
        BS_IDLE   = 6'b000001,
        BS_PRIME0 = 6'b000010,
        BS_PRIME1 = 6'b000100,
        BS_ROUND  = 6'b001000,
        BS_UPDATE = 6'b010000,
        BS_DIGEST = 6'b100000
    } back_state_t;

    back_state_t state_reg, state_next;

    // block store: two banks of sixteen words
    logic [31:0] wbuf_reg [32];

    logic        fill_bank_reg, fill_bank_next;
    logic [3:0]  fill_cnt_reg, fill_cnt_next;
    logic [1:0]  bank_full_reg, bank_full_next;
    logic [1:0]  bank_end_reg, bank_end_next;
    logic        cmp_bank_reg, cmp_bank_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic [31:0] rw_reg [4];
    logic [31:0] rw_next [4];
    logic [31:0] chain_reg [4];
    logic [31:0] chain_next [4];
    logic [31:0] kw_reg, kw_next;
    logic [31:0] adk_reg, adk_next;
    logic        out_valid_reg, out_valid_next;
    logic [63:0] dlow_reg, dlow_next;
    logic [63:0] dhigh_reg, dhigh_next;

    logic [5:0]  rd_step;
    logic [31:0] rd_word;
    logic [31:0] kw_calc;
    logic [1:0]  phase;
    logic [31:0] f_val;
    logic [31:0] sum;
    logic [31:0] new_b;
    logic        slot_free;

    assign empty       = !out_valid_reg;
    assign digest_low  = dlow_reg;
    assign digest_high = dhigh_reg;
    assign slot_free   = !out_valid_reg || pop;
    assign q_pop       = !q_empty && !bank_full_reg[fill_bank_reg];

    assign bstat.rounding      = (state_reg == BS_ROUND);
    assign bstat.cmp_bank_full = bank_full_reg[cmp_bank_reg];

    // step constant plus message word, fetched ahead of use into kw_reg, then added to a in adk_reg
    always_comb
    begin
        case (state_reg)
            BS_PRIME0: rd_step = 6'd0;
            BS_PRIME1: rd_step = 6'd1;
            default:   rd_step = rnd_reg + 6'd2;
        endcase
    end

    assign rd_word = wbuf_reg[{cmp_bank_reg, md5_msg_index(rd_step)}];
    assign kw_calc = RoundConst[rd_step] + rd_word;

    // round function
    assign phase = rnd_reg[5:4];

    always_comb
    begin
        case (phase)
            2'd0:    f_val = (rw_reg[1] & rw_reg[2]) | (~rw_reg[1] & rw_reg[3]);
            2'd1:    f_val = (rw_reg[1] & rw_reg[3]) | (rw_reg[2] & ~rw_reg[3]);
            2'd2:    f_val = rw_reg[1] ^ rw_reg[2] ^ rw_reg[3];
            default: f_val = rw_reg[2] ^ (rw_reg[1] | ~rw_reg[3]);
        endcase
    end

    assign sum   = f_val + adk_reg;
    assign new_b = rw_reg[1] + md5_rotl(sum, md5_shift(phase, rnd_reg[1:0]));

    // block fill, sequencing and digest hand-off
    always_comb
    begin
        state_next     = state_reg;
        fill_bank_next = fill_bank_reg;
        fill_cnt_next  = fill_cnt_reg;
        bank_full_next = bank_full_reg;
        bank_end_next  = bank_end_reg;
        cmp_bank_next  = cmp_bank_reg;
        rnd_next       = rnd_reg;
        rw_next        = rw_reg;
        chain_next     = chain_reg;
        kw_next        = kw_reg;
        adk_next       = adk_reg;
        out_valid_next = out_valid_reg;
        dlow_next      = dlow_reg;
        dhigh_next     = dhigh_reg;

        if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            BS_IDLE:
            begin
                if (bank_full_reg[cmp_bank_reg])
                begin
                    state_next = BS_PRIME0;
                end
            end
            BS_PRIME0:
            begin
                rw_next    = chain_reg;
                kw_next    = kw_calc;
                state_next = BS_PRIME1;
            end
            BS_PRIME1:
            begin
                adk_next   = rw_reg[0] + kw_reg;
                kw_next    = kw_calc;
                rnd_next   = '0;
                state_next = BS_ROUND;
            end
            BS_ROUND:
            begin
                rw_next[0] = rw_reg[3];
                rw_next[1] = new_b;
                rw_next[2] = rw_reg[1];
                rw_next[3] = rw_reg[2];
                adk_next   = rw_reg[3] + kw_reg;
                kw_next    = kw_calc;
                rnd_next   = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    state_next = BS_UPDATE;
                end
            end
            BS_UPDATE:
            begin
                for (int k = 0; k < 4; k++)
                begin
                    chain_next[k] = chain_reg[k] + rw_reg[k];
                end
                if (bank_end_reg[cmp_bank_reg])
                begin
                    state_next = BS_DIGEST;
                end
                else
                begin
                    bank_full_next[cmp_bank_reg] = 1'b0;
                    cmp_bank_next = !cmp_bank_reg;
                    state_next    = BS_IDLE;
                end
            end
            BS_DIGEST:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    dlow_next      = {chain_reg[1], chain_reg[0]};
                    dhigh_next     = {chain_reg[3], chain_reg[2]};
                    chain_next[0]  = IvA;
                    chain_next[1]  = IvB;
                    chain_next[2]  = IvC;
                    chain_next[3]  = IvD;
                    bank_full_next[cmp_bank_reg] = 1'b0;
                    cmp_bank_next  = !cmp_bank_reg;
                    state_next     = BS_IDLE;
                end
            end
            default:
            begin
                state_next = BS_IDLE;
            end
        endcase

        // word fill into the free bank
        if (q_pop)
        begin
            fill_cnt_next = fill_cnt_reg + 4'd1;
            if (fill_cnt_reg == 4'd15)
            begin
                bank_full_next[fill_bank_reg] = 1'b1;
                bank_end_next[fill_bank_reg]  = q_rdata.msg_end;
                fill_bank_next = !fill_bank_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BS_IDLE;
            fill_bank_reg <= 1'b0;
            fill_cnt_reg  <= '0;
            bank_full_reg <= '0;
            bank_end_reg  <= '0;
            cmp_bank_reg  <= 1'b0;
            rnd_reg       <= '0;
            out_valid_reg <= 1'b0;
            chain_reg[0]  <= IvA;
            chain_reg[1]  <= IvB;
            chain_reg[2]  <= IvC;
            chain_reg[3]  <= IvD;
            for (int k = 0; k < 4; k++)
            begin
                rw_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            fill_bank_reg <= fill_bank_next;
            fill_cnt_reg  <= fill_cnt_next;
            bank_full_reg <= bank_full_next;
            bank_end_reg  <= bank_end_next;
            cmp_bank_reg  <= cmp_bank_next;
            rnd_reg       <= rnd_next;
            out_valid_reg <= out_valid_next;
            chain_reg     <= chain_next;
            rw_reg        <= rw_next;
        end
    end

    // datapath registers, no reset
    always_ff @(posedge clk)
    begin
        kw_reg    <= kw_next;
        adk_reg   <= adk_next;
        dlow_reg  <= dlow_next;
        dhigh_reg <= dhigh_next;
        if (q_pop)
        begin
            wbuf_reg[{fill_bank_reg, fill_cnt_reg}] <= q_rdata.word;
        end
    end

endmodule
